// ----- rtl/core/utf8d_pkg.sv -----
// Shared constants and decode functions for the UTF-8 stream decoder.
package utf8d_pkg;

    // Field widths of the byte and character channels.
    localparam int BYTE_W = 8;
    localparam int CP_W   = 31;
    localparam int LINE_W = 32;

    // Internal queue between the front and back parts; the depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Byte class boundaries.
    localparam logic [BYTE_W-1:0] CONT_MIN  = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_MAX  = 8'hBF;
    localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD5_MIN = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD6_MIN = 8'hFC;

    // Special code points.
    localparam logic [CP_W-1:0] CP_REPLACEMENT = 31'h0000_FFFD;
    localparam logic [CP_W-1:0] CP_NEWLINE     = 31'h0000_000A;

    // Line counter limits.
    localparam logic [LINE_W-1:0] LINE_FIRST = 32'h0000_0001;
    localparam logic [LINE_W-1:0] LINE_LAST  = 32'hFFFF_FFFF;

    // Number of continuation bytes that follow a lead byte (0xC0 and up).
    function automatic logic [2:0] class_of_lead(input logic [BYTE_W-1:0] lead);
        logic [2:0] cls;
        if (lead < LEAD3_MIN) begin
            cls = 3'd1;
        end else if (lead < LEAD4_MIN) begin
            cls = 3'd2;
        end else if (lead < LEAD5_MIN) begin
            cls = 3'd3;
        end else if (lead < LEAD6_MIN) begin
            cls = 3'd4;
        end else begin
            cls = 3'd5;
        end
        return cls;
    endfunction

    // Mask that keeps the payload bits of a finished sequence.
    function automatic logic [CP_W-1:0] len_mask(input logic [2:0] cls);
        logic [CP_W-1:0] mask;
        case (cls)
            3'd1:    mask = 31'h0000_07FF;
            3'd2:    mask = 31'h0000_FFFF;
            3'd3:    mask = 31'h001F_FFFF;
            3'd4:    mask = 31'h03FF_FFFF;
            default: mask = 31'h7FFF_FFFF;
        endcase
        return mask;
    endfunction

endpackage

// ----- rtl/core/utf8d_if.sv -----
// Valid/ready channel interfaces of the UTF-8 stream decoder.
interface utf8d_byte_if import utf8d_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface utf8d_cp_if import utf8d_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;

    modport source (output valid, output code_point, input ready);
    modport sink   (input valid, input code_point, output ready);
endinterface

interface utf8d_char_if import utf8d_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CP_W-1:0]   code_point;
    logic [LINE_W-1:0] line_number;

    modport source (output valid, output code_point, output line_number, input ready);
    modport sink   (input valid, input code_point, input line_number, output ready);
endinterface

// ----- rtl/core/utf8_stream_decoder.sv -----
// Top level of the UTF-8 stream decoder with six-byte sequences and line counting.
//
//  Channel | Direction | Payload                          | Transfer
//  i_in    | in        | data_byte[7:0], end_of_input     | valid && ready
//  o_out   | out       | code_point[30:0], line_number    | valid && ready
//
// One byte is taken per clock while the queue has room. The code point of a
// completing byte enters the four-entry queue at the edge that takes the byte
// and moves from there into the output register, from which it transfers
// when the output is ready. Input ready falls only when the queue is full,
// that is with five results waiting behind a stalled output.
// Reset is synchronous and active low; it closes any open sequence and sets
// the line counter to one. Either side may stall without losing a transfer.
module utf8_stream_decoder import utf8d_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    utf8d_byte_if.sink    i_in,
    utf8d_char_if.source  o_out
);

    utf8d_cp_if u_front_cp ();
    utf8d_cp_if u_back_cp ();

    // Byte classification and sequence assembly.
    utf8d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_cp    (u_front_cp.source)
    );

    // Decoupling queue.
    utf8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cp    (u_front_cp.sink),
        .o_cp    (u_back_cp.source)
    );

    // Line counting and output register.
    utf8d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cp    (u_back_cp.sink),
        .o_out   (o_out)
    );

    // The line number shown is never zero.
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.line_number != '0)
        else $error("line number is zero");

    // Line numbers never go back between results.
    a_line_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && $past(o_out.valid && o_out.ready && i_rst_n))
        |-> o_out.line_number >= $past(o_out.line_number))
        else $error("line number decreased");

    // Only a newline moves the line number on.
    a_line_step_on_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && $past(o_out.valid && o_out.ready && i_rst_n)
         && o_out.line_number != $past(o_out.line_number))
        |-> o_out.code_point == CP_NEWLINE)
        else $error("line number changed without a newline");

endmodule

// ----- rtl/core/utf8d_front.sv -----
// Front part: accepts bytes, tracks the open sequence and emits decoded code points.
module utf8d_front import utf8d_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    utf8d_byte_if.sink   i_in,
    utf8d_cp_if.source   o_cp
);

    logic [CP_W-1:0] r_acc, n_acc;
    logic [2:0]      r_rem, n_rem;
    logic [2:0]      r_cls, n_cls;
    logic            accept;
    logic            emit;
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] shifted;
    logic [2:0]      lead_cls;

    // A byte is taken whenever the queue has room for a possible result.
    assign i_in.ready = o_cp.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign shifted    = {r_acc[CP_W-7:0], i_in.data_byte[5:0]};
    assign lead_cls   = class_of_lead(i_in.data_byte);

    // Classify the byte against the sequence state.
    always_comb begin
        n_acc = r_acc;
        n_rem = r_rem;
        n_cls = r_cls;
        emit  = 1'b0;
        cp    = '0;
        if (accept) begin
            if (i_in.end_of_input) begin
                // End of input inside a sequence yields a replacement character.
                if (r_rem != 3'd0) begin
                    emit  = 1'b1;
                    cp    = CP_REPLACEMENT;
                    n_acc = '0;
                    n_rem = 3'd0;
                    n_cls = 3'd0;
                end
            end else if (r_rem != 3'd0) begin
                // Continuation: append six bits, finish when the last one arrives.
                n_acc = shifted;
                n_rem = r_rem - 3'd1;
                if (r_rem == 3'd1) begin
                    emit  = 1'b1;
                    cp    = shifted & len_mask(r_cls);
                    n_acc = '0;
                    n_cls = 3'd0;
                end
            end else if (i_in.data_byte < CONT_MIN) begin
                emit = 1'b1;
                cp   = {{(CP_W-BYTE_W){1'b0}}, i_in.data_byte};
            end else if (i_in.data_byte inside {[CONT_MIN:CONT_MAX]}) begin
                // Stray continuation byte.
                emit = 1'b1;
                cp   = CP_REPLACEMENT;
            end else begin
                // Lead byte opens a sequence.
                n_cls = lead_cls;
                n_rem = lead_cls;
                n_acc = {{(CP_W-BYTE_W){1'b0}}, i_in.data_byte};
            end
        end
    end

    assign o_cp.valid      = emit;
    assign o_cp.code_point = cp;

    // Sequence state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_rem <= 3'd0;
            r_cls <= 3'd0;
        end else begin
            r_acc <= n_acc;
            r_rem <= n_rem;
            r_cls <= n_cls;
        end
    end

endmodule

// ----- rtl/core/utf8d_queue.sv -----
// Short queue of code points between the front and back parts.
module utf8d_queue import utf8d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    utf8d_cp_if.sink    i_cp,
    utf8d_cp_if.source  o_cp
);

    localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(QUEUE_DEPTH);

    logic [CP_W-1:0]   r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              push, pop;

    assign i_cp.ready      = (r_count != DEPTH_CNT);
    assign o_cp.valid      = (r_count != '0);
    assign o_cp.code_point = r_mem[r_rd];
    assign push            = i_cp.valid && i_cp.ready;
    assign pop             = o_cp.valid && o_cp.ready;

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_cp.code_point;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/core/utf8d_back.sv -----
// Back part: counts lines and holds the result in the output register.
module utf8d_back import utf8d_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    utf8d_cp_if.sink      i_cp,
    utf8d_char_if.source  o_out
);

    logic              r_valid;
    logic [CP_W-1:0]   r_cp;
    logic [LINE_W-1:0] r_line_out;
    logic [LINE_W-1:0] r_line, n_line;
    logic              pop;

    assign i_cp.ready = !r_valid || o_out.ready;
    assign pop        = i_cp.valid && i_cp.ready;

    // Saturating line count after the popped character.
    always_comb begin
        n_line = r_line;
        if (i_cp.code_point == CP_NEWLINE && r_line != LINE_LAST) begin
            n_line = r_line + LINE_W'(1);
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cp       <= i_cp.code_point;
            r_line_out <= n_line;
        end
    end

    // Output valid and line counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_line  <= LINE_FIRST;
        end else begin
            if (pop) begin
                r_valid <= 1'b1;
                r_line  <= n_line;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.code_point  = r_cp;
    assign o_out.line_number = r_line_out;

endmodule
